FILE: hw/rtl/lzss_rd_pkg.sv
// shared types and constants for the lzss ring decoder
// used by lzss_rd_window and lzss_ring_decoder; no dependencies
package lzss_rd_pkg;

  localparam int WIN_SIZE       = 4096;
  localparam int WIN_AW         = $clog2(WIN_SIZE);
  localparam int LOOKAHEAD      = 16;
  localparam int MIN_MATCH_BIAS = 2;

  localparam logic [7:0]        FILL_CHAR  = 8'h20;
  localparam logic [WIN_AW-1:0] WP_RESET   = WIN_AW'(WIN_SIZE - LOOKAHEAD);
  localparam logic [WIN_AW-1:0] WIN_LAST   = WIN_AW'(WIN_SIZE - 1);
  localparam logic [4:0]        LEN_OFFSET = 5'(MIN_MATCH_BIAS + 1);

  // window write port
  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
    logic [7:0]        data;
  } win_wr_t;

  // window read port
  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
  } win_rd_t;

endpackage

FILE: hw/rtl/lzss_rd_window.sv
// 4096 x 8 history window, one write and one registered read a cycle
// depends on lzss_rd_pkg
module lzss_rd_window (
  input  logic                clk,
  input  lzss_rd_pkg::win_wr_t wr,
  input  lzss_rd_pkg::win_rd_t rd,
  output logic [7:0]          rd_q
);
  import lzss_rd_pkg::*;

  logic [7:0] mem [WIN_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q <= mem[rd.addr];
    end
  end

endmodule

FILE: hw/rtl/lzss_ring_decoder.sv
// lzss decompressor with a 4096-byte ring window, top level
// depends on lzss_rd_pkg and lzss_rd_window
//
//  channel  direction  fields (tdata low bit up)         notes
//  in_*     slave      tdata[7:0] = in_byte              flag, literal or pair byte
//  out_*    master     tdata[7:0] = out_byte             tlast = last_of_run
//
// after reset the window is filled one entry a cycle, with in_tready low.
// every byte is taken only while the output slot is free or being drained.
// a flag, literal or first pair byte is taken alone; the second pair byte starts a copy
// of 3 to 18 bytes, one copied byte a cycle through the single window read port;
// a stalled output pauses the copy.
// reset is synchronous, active low, and also restarts the stream.
module lzss_ring_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import lzss_rd_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_COPY  = 2'd2;

  // input phase codes
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_ITEM  = 2'd1;
  localparam logic [1:0] PH_PAIR2 = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [15:0]       flags_r, flags_nxt;
  logic [7:0]        off_lo_r, off_lo_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [WIN_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [WIN_AW-1:0] src_r, src_nxt;
  logic [4:0]        rem_r, rem_nxt;
  logic              byp_r, byp_nxt;
  logic [7:0]        byp_data_r, byp_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  win_wr_t    wr;
  win_rd_t    rd;
  logic [7:0] rd_q;
  logic       out_free;
  logic       in_acc;
  logic [7:0] copy_byte;
  logic [15:0] flags_shift;

  lzss_rd_window u_window (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rd_q (rd_q)
  );

  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = (state_r == ST_IDLE) && out_free;
  assign in_acc      = in_tvalid && in_tready;
  assign copy_byte   = byp_r ? byp_data_r : rd_q;
  assign flags_shift = flags_r >> 1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    flags_nxt     = flags_r;
    off_lo_nxt    = off_lo_r;
    wp_nxt        = wp_r;
    clr_cnt_nxt   = clr_cnt_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    byp_nxt       = byp_r;
    byp_data_nxt  = byp_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    wr            = '0;
    rd            = '0;

    unique case (state_r)
      // fill the window with its start-up contents
      ST_CLEAR: begin
        wr.en       = 1'b1;
        wr.addr     = clr_cnt_r;
        wr.data     = (clr_cnt_r >= WP_RESET) ? 8'h00 : FILL_CHAR;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == WIN_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      // take one input byte
      ST_IDLE: begin
        if (in_acc) begin
          if (phase_r == PH_ITEM) begin
            if (flags_r[0]) begin
              // literal
              wr.en         = 1'b1;
              wr.addr       = wp_r;
              wr.data       = in_tdata;
              wp_nxt        = wp_r + 1'b1;
              out_valid_nxt = 1'b1;
              out_byte_nxt  = in_tdata;
              out_last_nxt  = 1'b1;
              flags_nxt     = flags_shift;
              phase_nxt     = flags_shift[8] ? PH_ITEM : PH_FLAG;
            end else begin
              off_lo_nxt = in_tdata;
              phase_nxt  = PH_PAIR2;
            end
          end else if (phase_r == PH_PAIR2) begin
            // start the copy with the first window read
            rd.en     = 1'b1;
            rd.addr   = {in_tdata[7:4], off_lo_r};
            src_nxt   = {in_tdata[7:4], off_lo_r} + 1'b1;
            rem_nxt   = {1'b0, in_tdata[3:0]} + LEN_OFFSET;
            byp_nxt   = 1'b0;
            state_nxt = ST_COPY;
          end else begin
            // flag byte
            flags_nxt = {8'hff, in_tdata};
            phase_nxt = PH_ITEM;
          end
        end
      end

      // emit one copied byte a cycle while the output slot is free, and read the next
      ST_COPY: begin
        if (out_free) begin
          wr.en         = 1'b1;
          wr.addr       = wp_r;
          wr.data       = copy_byte;
          wp_nxt        = wp_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = copy_byte;
          out_last_nxt  = (rem_r == 5'd1);
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == 5'd1) begin
            flags_nxt = flags_shift;
            phase_nxt = flags_shift[8] ? PH_ITEM : PH_FLAG;
            state_nxt = ST_IDLE;
          end else begin
            rd.en        = 1'b1;
            rd.addr      = src_r;
            src_nxt      = src_r + 1'b1;
            // source is the byte being written now
            byp_nxt      = (src_r == wp_r);
            byp_data_nxt = copy_byte;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= PH_FLAG;
      flags_r     <= '0;
      off_lo_r    <= '0;
      wp_r        <= WP_RESET;
      clr_cnt_r   <= '0;
      rem_r       <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      off_lo_r    <= off_lo_nxt;
      wp_r        <= wp_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rem_r       <= rem_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    byp_data_r <= byp_data_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
